// ----- src/tmcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile mean color classifier package
// Shared constants, register indexes, sequencer state and channel select
// types used by the configuration registers and the classifier core.
// ----------------------------------------------------------------------------
package tmcc_pkg;

	// Pixel and palette packing.
	localparam int CHAN_W        = 8;
	localparam int NUM_CHANNELS  = 3;
	localparam int PAL_ENTRY_W   = NUM_CHANNELS * CHAN_W;

	// Configuration port.
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = PAL_ENTRY_W;
	localparam int SIDE_REG_W    = 7;
	localparam int NUM_PAL_REGS  = 5;
	localparam int SIDE_RESET    = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_0   = 3'd2;

	// Distance search starts from the square of the no-match bound, which is
	// larger than any real squared distance.
	localparam int NO_MATCH_BOUND = 1000;
	localparam int BEST_INIT      = NO_MATCH_BOUND * NO_MATCH_BOUND;
	localparam int DIST_W         = $clog2(BEST_INIT + 1);

	// Output field width of the palette index.
	localparam int OUT_IDX_W      = 3;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_DIST,
		ST_DONE
	} state_t;

	// Channel being worked on; the compare slot closes one palette entry.
	typedef enum logic [1:0] {
		CH_FIRST,
		CH_SECOND,
		CH_THIRD,
		CH_CMP
	} chan_sel_t;

	function automatic logic [CHAN_W-1:0] pal_byte(
		input logic [PAL_ENTRY_W-1:0] entry,
		input chan_sel_t              sel
	);
		logic [CHAN_W-1:0] b;
		case (sel)
			CH_FIRST:  b = entry[23:16];
			CH_SECOND: b = entry[15:8];
			CH_THIRD:  b = entry[7:0];
			default:   b = '0;
		endcase
		return b;
	endfunction

endpackage

// ----- src/tmcc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Tile mean color classifier configuration registers
// Holds tile size and palette, clamps the tile sides and registers the area.
// ----------------------------------------------------------------------------
module tmcc_cfg_regs #(
	parameter int MAX_TILE_SIDE = 64,
	parameter int PALETTE_SIZE  = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [tmcc_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [tmcc_pkg::CFG_DATA_W-1:0]     wr_data,
	output logic [$clog2(MAX_TILE_SIDE*MAX_TILE_SIDE+1)-1:0] area,
	output logic                                settling,
	output logic [tmcc_pkg::PAL_ENTRY_W-1:0]    palette [PALETTE_SIZE]
);

	localparam int SIDE_W    = $clog2(MAX_TILE_SIDE + 1);
	localparam int CMP_W     = (SIDE_W > tmcc_pkg::SIDE_REG_W) ? SIDE_W : tmcc_pkg::SIDE_REG_W;
	localparam int AREA_W    = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE + 1);
	localparam int RST_SIDE  = (tmcc_pkg::SIDE_RESET > MAX_TILE_SIDE) ?
	                           MAX_TILE_SIDE : tmcc_pkg::SIDE_RESET;
	localparam int RST_AREA  = RST_SIDE * RST_SIDE;
	localparam logic [CMP_W-1:0] MAX_SIDE = CMP_W'(MAX_TILE_SIDE);

	logic [tmcc_pkg::SIDE_REG_W-1:0] width_q;
	logic [tmcc_pkg::SIDE_REG_W-1:0] height_q;
	logic [SIDE_W-1:0]               width_cl;
	logic [SIDE_W-1:0]               height_cl;
	logic [2*SIDE_W-1:0]             area_prod;
	logic [AREA_W-1:0]               area_q;
	logic                            settling_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tmcc_pkg::SIDE_REG_W'(tmcc_pkg::SIDE_RESET);
			height_q <= tmcc_pkg::SIDE_REG_W'(tmcc_pkg::SIDE_RESET);
		end else if (wr_en) begin
			if (wr_index == tmcc_pkg::REG_TILE_WIDTH) begin
				width_q <= wr_data[tmcc_pkg::SIDE_REG_W-1:0];
			end
			if (wr_index == tmcc_pkg::REG_TILE_HEIGHT) begin
				height_q <= wr_data[tmcc_pkg::SIDE_REG_W-1:0];
			end
		end
	end

	// Entries beyond the register list are never written and stay zero.
	for (genvar e = 0; e < PALETTE_SIZE; e++) begin : g_pal
		if (e < tmcc_pkg::NUM_PAL_REGS) begin : g_wr
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					palette[e] <= '0;
				end else if (wr_en &&
				             wr_index == tmcc_pkg::REG_PALETTE_0 + tmcc_pkg::CFG_INDEX_W'(e)) begin
					palette[e] <= wr_data;
				end
			end
		end else begin : g_zero
			assign palette[e] = '0;
		end
	end

	// A side of zero counts as one; a side above the maximum is cut to it.
	always_comb begin
		if (width_q == '0) begin
			width_cl = SIDE_W'(1);
		end else if (CMP_W'(width_q) > MAX_SIDE) begin
			width_cl = SIDE_W'(MAX_TILE_SIDE);
		end else begin
			width_cl = SIDE_W'(width_q);
		end
		if (height_q == '0) begin
			height_cl = SIDE_W'(1);
		end else if (CMP_W'(height_q) > MAX_SIDE) begin
			height_cl = SIDE_W'(MAX_TILE_SIDE);
		end else begin
			height_cl = SIDE_W'(height_q);
		end
	end

	assign area_prod = (2*SIDE_W)'(width_cl) * (2*SIDE_W)'(height_cl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q     <= AREA_W'(RST_AREA);
			settling_q <= 1'b0;
		end else begin
			area_q     <= AREA_W'(area_prod);
			settling_q <= wr_en;
		end
	end

	assign area     = area_q;
	assign settling = settling_q;

endmodule

// ----- src/tile_mean_color_classifier.sv -----
// ----------------------------------------------------------------------------
// Tile mean color classifier
// Averages the pixels of a tile per channel and names the nearest palette
// color by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Pixels arrive one beat at a time on the input channel and are taken at one
// per cycle while a tile fills; the only gap is the cycle after each
// configuration write, while the tile area register settles. When the beat
// that completes the tile is taken, the block stops taking pixels and runs a
// shared compare-and-subtract unit as a restoring divider, nine steps per
// channel, then a shared square-and-add unit over the palette, one channel
// per step and a compare slot per entry, then moves the result into the
// output register. The input stays blocked from the last pixel of a tile until
// that move, which also waits while the previous result is still untaken.
// The output register lets the next tile fill while a result waits. Means
// saturate at 255 when the tile size was reduced mid-tile, and the lowest
// palette index wins a tie.
// ----------------------------------------------------------------------------
module tile_mean_color_classifier #(
	parameter int MAX_TILE_SIDE = 64,
	parameter int PALETTE_SIZE  = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tmcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tmcc_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [tmcc_pkg::CHAN_W-1:0]          chan_first,
	input  logic [tmcc_pkg::CHAN_W-1:0]          chan_second,
	input  logic [tmcc_pkg::CHAN_W-1:0]          chan_third,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tmcc_pkg::CHAN_W-1:0]          mean_first,
	output logic [tmcc_pkg::CHAN_W-1:0]          mean_second,
	output logic [tmcc_pkg::CHAN_W-1:0]          mean_third,
	output logic [tmcc_pkg::OUT_IDX_W-1:0]       nearest_index
);

	localparam int CW        = tmcc_pkg::CHAN_W;
	localparam int AREA_W    = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE + 1);
	localparam int SUM_W     = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE * 255 + 1);
	localparam int DIV_W     = AREA_W + CW;
	localparam int STEP_W    = $clog2(CW + 1);
	localparam int PAL_IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam int DW        = tmcc_pkg::DIST_W;

	localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(CW);
	localparam logic [PAL_IDX_W-1:0] LAST_ENT  = PAL_IDX_W'(PALETTE_SIZE - 1);

	// Configuration.
	logic [AREA_W-1:0]                area;
	logic                             settling;
	logic [tmcc_pkg::PAL_ENTRY_W-1:0] palette [PALETTE_SIZE];

	// Sequencer.
	tmcc_pkg::state_t    state_q, state_d;
	tmcc_pkg::chan_sel_t ch_q;
	tmcc_pkg::chan_sel_t ch_next;
	logic [STEP_W-1:0]   step_q;
	logic [PAL_IDX_W-1:0] ent_q;

	// Accumulation.
	logic [SUM_W-1:0]  sum_q [tmcc_pkg::NUM_CHANNELS];
	logic [AREA_W-1:0] count_q;
	logic [AREA_W-1:0] count_inc;
	logic [SUM_W-1:0]  sum_next_first;
	logic              pix_beat;
	logic              tile_end;

	// Divider.
	logic [SUM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [CW-1:0]     quot_q;
	logic              div_ge;
	logic [CW-1:0]     div_mean;
	logic [SUM_W-1:0]  div_src;
	logic              div_last;
	logic [CW-1:0]     mean_q [tmcc_pkg::NUM_CHANNELS];

	// Distance unit.
	logic [CW-1:0]     pal_b;
	logic [CW-1:0]     mean_b;
	logic [CW-1:0]     diff;
	logic [2*CW-1:0]   diff_sq;
	logic [DW-1:0]     acc_q;
	logic [DW-1:0]     best_q;
	logic [PAL_IDX_W-1:0] best_idx_q;
	logic              dist_last;

	// Output register.
	logic              out_valid_q;
	logic              out_free;
	logic [CW-1:0]     out_mean_q [tmcc_pkg::NUM_CHANNELS];
	logic [PAL_IDX_W-1:0] out_idx_q;

	tmcc_cfg_regs #(
		.MAX_TILE_SIDE (MAX_TILE_SIDE),
		.PALETTE_SIZE  (PALETTE_SIZE)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.area     (area),
		.settling (settling),
		.palette  (palette)
	);

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmcc_pkg::ST_ACC: begin
				if (pix_beat && tile_end) begin
					state_d = tmcc_pkg::ST_DIV;
				end
			end
			tmcc_pkg::ST_DIV: begin
				if (div_last && ch_q == tmcc_pkg::CH_THIRD) begin
					state_d = tmcc_pkg::ST_DIST;
				end
			end
			tmcc_pkg::ST_DIST: begin
				if (dist_last) begin
					state_d = tmcc_pkg::ST_DONE;
				end
			end
			tmcc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = tmcc_pkg::ST_ACC;
				end
			end
			default: state_d = tmcc_pkg::ST_ACC;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs and step decodes.
	// ------------------------------------------------------------------
	always_comb begin
		in_ready  = (state_q == tmcc_pkg::ST_ACC) && !settling;
		pix_beat  = in_valid && in_ready;
		out_free  = !out_valid_q || out_ready;
		div_last  = (step_q == LAST_STEP);
		dist_last = (ch_q == tmcc_pkg::CH_CMP) && (ent_q == LAST_ENT);
	end

	always_comb begin
		case (ch_q)
			tmcc_pkg::CH_FIRST:  ch_next = tmcc_pkg::CH_SECOND;
			tmcc_pkg::CH_SECOND: ch_next = tmcc_pkg::CH_THIRD;
			tmcc_pkg::CH_THIRD:  ch_next = tmcc_pkg::CH_CMP;
			default:             ch_next = tmcc_pkg::CH_FIRST;
		endcase
	end

	// The tile closes once the count including this pixel reaches the area.
	assign count_inc      = count_q + AREA_W'(1);
	assign tile_end       = (count_inc >= area);
	assign sum_next_first = sum_q[0] + SUM_W'(chan_first);

	// ------------------------------------------------------------------
	// Divider unit: one compare and subtract per cycle. The first step
	// tests the sum against the area times 256, which flags saturation;
	// the remaining eight steps give the quotient bits.
	// ------------------------------------------------------------------
	assign div_ge   = (DIV_W'(rem_q) >= div_q);
	assign div_mean = quot_q[CW-1] ? {CW{1'b1}} : {quot_q[CW-2:0], div_ge};

	always_comb begin
		case (ch_q)
			tmcc_pkg::CH_FIRST: div_src = sum_q[1];
			default:            div_src = sum_q[2];
		endcase
	end

	// ------------------------------------------------------------------
	// Distance unit: one channel's squared difference per cycle, then a
	// compare slot that keeps the strictly smaller distance.
	// ------------------------------------------------------------------
	always_comb begin
		pal_b = tmcc_pkg::pal_byte(palette[ent_q], ch_q);
		case (ch_q)
			tmcc_pkg::CH_FIRST:  mean_b = mean_q[0];
			tmcc_pkg::CH_SECOND: mean_b = mean_q[1];
			tmcc_pkg::CH_THIRD:  mean_b = mean_q[2];
			default:             mean_b = '0;
		endcase
		diff    = (pal_b > mean_b) ? (pal_b - mean_b) : (mean_b - pal_b);
		diff_sq = (2*CW)'(diff) * (2*CW)'(diff);
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmcc_pkg::ST_ACC;
			ch_q        <= tmcc_pkg::CH_FIRST;
			step_q      <= '0;
			ent_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < tmcc_pkg::NUM_CHANNELS; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			// A new result may load in the same cycle the old one is taken.
			if (state_q == tmcc_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				tmcc_pkg::ST_ACC: begin
					if (pix_beat) begin
						sum_q[0] <= sum_next_first;
						sum_q[1] <= sum_q[1] + SUM_W'(chan_second);
						sum_q[2] <= sum_q[2] + SUM_W'(chan_third);
						count_q  <= tile_end ? '0 : count_inc;
						ch_q     <= tmcc_pkg::CH_FIRST;
						step_q   <= '0;
					end
				end
				tmcc_pkg::ST_DIV: begin
					if (div_last) begin
						step_q <= '0;
						if (ch_q == tmcc_pkg::CH_THIRD) begin
							ch_q  <= tmcc_pkg::CH_FIRST;
							ent_q <= '0;
							for (int i = 0; i < tmcc_pkg::NUM_CHANNELS; i++) begin
								sum_q[i] <= '0;
							end
						end else begin
							ch_q <= ch_next;
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				tmcc_pkg::ST_DIST: begin
					ch_q <= ch_next;
					if (ch_q == tmcc_pkg::CH_CMP && !dist_last) begin
						ent_q <= ent_q + PAL_IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			tmcc_pkg::ST_ACC: begin
				if (pix_beat && tile_end) begin
					rem_q <= sum_next_first;
					div_q <= {area, CW'(0)};
				end
			end
			tmcc_pkg::ST_DIV: begin
				if (div_last) begin
					case (ch_q)
						tmcc_pkg::CH_FIRST:  mean_q[0] <= div_mean;
						tmcc_pkg::CH_SECOND: mean_q[1] <= div_mean;
						default:             mean_q[2] <= div_mean;
					endcase
					rem_q  <= div_src;
					div_q  <= {area, CW'(0)};
					best_q <= DW'(tmcc_pkg::BEST_INIT);
				end else begin
					rem_q  <= div_ge ? (rem_q - SUM_W'(div_q)) : rem_q;
					div_q  <= div_q >> 1;
					quot_q <= {quot_q[CW-2:0], div_ge};
				end
			end
			tmcc_pkg::ST_DIST: begin
				if (ch_q == tmcc_pkg::CH_CMP) begin
					if (acc_q < best_q) begin
						best_q     <= acc_q;
						best_idx_q <= ent_q;
					end
				end else if (ch_q == tmcc_pkg::CH_FIRST) begin
					acc_q <= DW'(diff_sq);
				end else begin
					acc_q <= acc_q + DW'(diff_sq);
				end
			end
			tmcc_pkg::ST_DONE: begin
				if (out_free) begin
					out_mean_q[0] <= mean_q[0];
					out_mean_q[1] <= mean_q[1];
					out_mean_q[2] <= mean_q[2];
					out_idx_q     <= best_idx_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign mean_first    = out_mean_q[0];
	assign mean_second   = out_mean_q[1];
	assign mean_third    = out_mean_q[2];
	assign nearest_index = tmcc_pkg::OUT_IDX_W'(out_idx_q);

endmodule

// ----- sim/tile_mean_color_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// Tile mean color classifier testbench
// Streams pixel beats into the classifier under random source gaps and sink
// stalls, predicts each tile's channel means and nearest palette color, and
// checks every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tile_mean_color_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmcc_pkg::*;

	// Block parameters as instantiated below.
	localparam int MAX_SIDE   = 64;
	localparam int NUM_COLORS = 5;

	// The index after the last palette register maps to nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

	// Settling margin after a drain; it covers the time from the last pixel of a
	// tile to its result with room to spare.
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_GAP       = 19;
	localparam int RANDOM_PIXELS = 1000;

	typedef struct packed {
		logic [CHAN_W-1:0] ch_first;
		logic [CHAN_W-1:0] ch_second;
		logic [CHAN_W-1:0] ch_third;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0]    avg_first;
		logic [CHAN_W-1:0]    avg_second;
		logic [CHAN_W-1:0]    avg_third;
		logic [OUT_IDX_W-1:0] nearest;
	} tile_class_t;

	// How the pixels of one tile are made up.
	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_NEAR,
		FILL_EXTREME,
		FILL_BRIGHT
	} fill_t;

	logic                   clk;
	logic                   arst_n      = 1'b0;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic [CHAN_W-1:0]      chan_first  = '0;
	logic [CHAN_W-1:0]      chan_second = '0;
	logic [CHAN_W-1:0]      chan_third  = '0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic [CHAN_W-1:0]      mean_first;
	logic [CHAN_W-1:0]      mean_second;
	logic [CHAN_W-1:0]      mean_third;
	logic [OUT_IDX_W-1:0]   nearest_index;

	tile_mean_color_classifier #(
		.MAX_TILE_SIDE(MAX_SIDE),
		.PALETTE_SIZE (NUM_COLORS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.chan_first   (chan_first),
		.chan_second  (chan_second),
		.chan_third   (chan_third),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_first   (mean_first),
		.mean_second  (mean_second),
		.mean_third   (mean_third),
		.nearest_index(nearest_index)
	);

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the registers and the accumulators.
	// The register copy changes when a write beat is taken, the accumulators
	// when a pixel beat is taken.
	// ------------------------------------------------------------------------
	logic [SIDE_REG_W-1:0]  width_reg  = SIDE_REG_W'(SIDE_RESET);
	logic [SIDE_REG_W-1:0]  height_reg = SIDE_REG_W'(SIDE_RESET);
	logic [PAL_ENTRY_W-1:0] palette_reg [NUM_COLORS] = '{default: '0};
	logic [19:0]            sum_first_acc  = '0;
	logic [19:0]            sum_second_acc = '0;
	logic [19:0]            sum_third_acc  = '0;
	logic [12:0]            pixels_in_tile = '0;

	// Classifications predicted but not yet seen on the result channel.
	tile_class_t tile_classes_due [$];

	// Pixels waiting for the driver, and the two counters that tell the
	// stimulus when every queued pixel has been taken.
	pixel_t      pixel_backlog [$];
	int unsigned pixels_queued = 0;
	int unsigned pixels_taken  = 0;
	int unsigned failures      = 0;

	// A side register of zero acts as one, anything above the maximum side
	// acts as the maximum.
	function automatic int unsigned eff_side(input logic [SIDE_REG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return 32'(v);
	endfunction

	function automatic int unsigned tile_area();
		return eff_side(width_reg) * eff_side(height_reg);
	endfunction

	// The mean can exceed a byte only when the tile was shrunk while it was
	// filling; it then saturates.
	function automatic logic [CHAN_W-1:0] clipped_mean(input logic [19:0] sum,
			input int unsigned area);
		int unsigned m;
		m = sum / area;
		if (m > 255)
			m = 255;
		return m[CHAN_W-1:0];
	endfunction

	function automatic int unsigned sq_dist(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	// Adds one pixel to the tile and, when the tile is complete, predicts its
	// means and nearest palette entry. A strict less-than keeps the lowest
	// index on a tie.
	task automatic absorb_pixel(input pixel_t p);
		int unsigned area;
		int unsigned d;
		int unsigned best;
		tile_class_t res;
		sum_first_acc  += 20'(p.ch_first);
		sum_second_acc += 20'(p.ch_second);
		sum_third_acc  += 20'(p.ch_third);
		pixels_in_tile++;
		area = tile_area();
		if (pixels_in_tile >= area) begin
			res.avg_first  = clipped_mean(sum_first_acc, area);
			res.avg_second = clipped_mean(sum_second_acc, area);
			res.avg_third  = clipped_mean(sum_third_acc, area);
			res.nearest    = '0;
			best = BEST_INIT;
			for (int k = 0; k < NUM_COLORS; k++) begin
				d = sq_dist(palette_reg[k][23:16], res.avg_first)
				  + sq_dist(palette_reg[k][15:8], res.avg_second)
				  + sq_dist(palette_reg[k][7:0], res.avg_third);
				if (d < best) begin
					best = d;
					res.nearest = OUT_IDX_W'(k);
				end
			end
			tile_classes_due.push_back(res);
			sum_first_acc  = '0;
			sum_second_acc = '0;
			sum_third_acc  = '0;
			pixels_in_tile = '0;
		end
	endtask

	function automatic int unsigned draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// ------------------------------------------------------------------------
	// Clock and timeout.
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("** tile_mean_color_classifier: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Pixel driver. A beat is offered after a drawn number of idle cycles and
	// held until taken. Now and then the driver switches into a burst mode
	// with no gaps at all, so back-to-back beats hit the block too.
	// ------------------------------------------------------------------------
	pixel_t      pixel_on_bus;
	int unsigned pixel_gap = 0;
	bit          in_burst  = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				absorb_pixel(pixel_on_bus);
				pixels_taken++;
				if ($urandom_range(0, 39) == 0)
					in_burst = !in_burst;
				pixel_gap = draw_wait(in_burst);
			end
			if (!in_valid || in_ready) begin
				if (pixel_gap == 0 && pixel_backlog.size() != 0) begin
					pixel_on_bus = pixel_backlog.pop_front();
					in_valid    <= 1'b1;
					chan_first  <= pixel_on_bus.ch_first;
					chan_second <= pixel_on_bus.ch_second;
					chan_third  <= pixel_on_bus.ch_third;
				end else begin
					if (pixel_gap != 0)
						pixel_gap--;
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor. After each result beat the sink stalls for a drawn
	// number of cycles, again with stretches of no stalling at all.
	// ------------------------------------------------------------------------
	tile_class_t wanted;
	int unsigned result_stall = 0;
	bit          out_burst    = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (tile_classes_due.size() == 0) begin
					$error("result beat with none expected: means %0d/%0d/%0d, index %0d",
						mean_first, mean_second, mean_third, nearest_index);
					failures++;
				end else begin
					wanted = tile_classes_due.pop_front();
					if (mean_first !== wanted.avg_first) begin
						$error("mean_first: expected %0d, got %0d", wanted.avg_first,
							mean_first);
						failures++;
					end
					if (mean_second !== wanted.avg_second) begin
						$error("mean_second: expected %0d, got %0d", wanted.avg_second,
							mean_second);
						failures++;
					end
					if (mean_third !== wanted.avg_third) begin
						$error("mean_third: expected %0d, got %0d", wanted.avg_third,
							mean_third);
						failures++;
					end
					if (nearest_index !== wanted.nearest) begin
						$error("nearest_index: expected %0d, got %0d", wanted.nearest,
							nearest_index);
						failures++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					out_burst = !out_burst;
				result_stall = draw_wait(out_burst);
			end
			if (result_stall != 0) begin
				result_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	// Must be called right after a rising edge. Back-to-back writes keep
	// cfg_valid high; the caller lowers it after the last one.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		int slot;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TILE_WIDTH) begin
			width_reg = data[SIDE_REG_W-1:0];
		end else if (idx == REG_TILE_HEIGHT) begin
			height_reg = data[SIDE_REG_W-1:0];
		end else if (idx >= REG_PALETTE_0 && idx < REG_PALETTE_0 + NUM_PAL_REGS) begin
			slot = int'(idx) - int'(REG_PALETTE_0);
			if (slot < NUM_COLORS)
				palette_reg[slot] = data;
		end
	endtask

	task automatic queue_pixel(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
			input logic [CHAN_W-1:0] c);
		pixel_backlog.push_back(pixel_t'{a, b, c});
		pixels_queued++;
	endtask

	// Waits until every queued pixel is taken and every predicted result has
	// arrived, then lets the block settle so that a register write never lands
	// on a tile still being classified.
	task automatic wait_for_drain();
		while (pixels_taken != pixels_queued || tile_classes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CHAN_W-1:0] jitter(input logic [CHAN_W-1:0] base);
		int v;
		v = int'(base) + int'($urandom_range(0, 14)) - 7;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return CHAN_W'(v);
	endfunction

	function automatic logic [CHAN_W-1:0] draw_channel();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return CHAN_W'($urandom());
		endcase
	endfunction

	// Mostly small sides so that results come often; now and then a zero or
	// an oversized value to hit the clamping.
	function automatic logic [SIDE_REG_W-1:0] draw_side(input bit allow_big);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (allow_big && r < 6)
			return (r < 2) ? SIDE_REG_W'(MAX_SIDE) : SIDE_REG_W'($urandom_range(65, 127));
		if (r < 10)
			return '0;
		if (r < 25)
			return SIDE_REG_W'($urandom_range(7, 12));
		return SIDE_REG_W'($urandom_range(1, 6));
	endfunction

	task automatic queue_tile(input int unsigned n, input fill_t style,
			input logic [PAL_ENTRY_W-1:0] color);
		for (int unsigned i = 0; i < n; i++) begin
			case (style)
				FILL_NEAR:
					queue_pixel(jitter(color[23:16]), jitter(color[15:8]),
						jitter(color[7:0]));
				FILL_EXTREME:
					queue_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00,
						$urandom_range(0, 1) ? 8'hFF : 8'h00,
						$urandom_range(0, 1) ? 8'hFF : 8'h00);
				FILL_BRIGHT:
					queue_pixel(8'hFF, CHAN_W'($urandom_range(192, 255)), CHAN_W'($urandom()));
				default:
					queue_pixel(CHAN_W'($urandom()), CHAN_W'($urandom()), CHAN_W'($urandom()));
			endcase
		end
	endtask

	// One random phase: new tile size, some palette entries rewritten, then a
	// few whole tiles whose pixels are random, extreme, bright, or clustered around a
	// palette color so that every index gets to win. A trailing partial tile
	// is carried into the next phase, where the size usually changes.
	task automatic random_phase();
		logic [SIDE_REG_W-1:0]  w;
		logic [SIDE_REG_W-1:0]  h;
		logic [CFG_DATA_W-1:0]  word;
		logic [CFG_INDEX_W-1:0] reg_idx;
		int unsigned            area;
		int unsigned            tiles;
		w = draw_side(1'b1);
		h = (eff_side(w) > 6) ? SIDE_REG_W'($urandom_range(0, 2))
		                      : draw_side(eff_side(w) <= 2);
		// The upper data bits are random; only the low seven reach the register.
		word = CFG_DATA_W'($urandom());
		word[SIDE_REG_W-1:0] = w;
		write_reg(REG_TILE_WIDTH, word);
		word = CFG_DATA_W'($urandom());
		word[SIDE_REG_W-1:0] = h;
		write_reg(REG_TILE_HEIGHT, word);
		for (int k = 0; k < NUM_PAL_REGS; k++) begin
			if ($urandom_range(0, 1) == 1) begin
				reg_idx = REG_PALETTE_0 + CFG_INDEX_W'(k);
				write_reg(reg_idx, {draw_channel(), draw_channel(), draw_channel()});
			end
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;

		area  = tile_area();
		tiles = $urandom_range(1, 4);
		repeat (tiles)
			queue_tile(area, fill_t'($urandom_range(0, 3)),
				palette_reg[$urandom_range(0, NUM_COLORS - 1)]);
		if (area > 1 && $urandom_range(0, 2) == 0)
			queue_tile($urandom_range(1, area - 1), FILL_RANDOM, '0);
		wait_for_drain();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	int unsigned random_target;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: a 20 by 20 tile against an all-black palette, so every
		// entry ties and index 0 must win.
		queue_tile(tile_area(), FILL_RANDOM, '0);
		wait_for_drain();

		// One-pixel tiles: a zero width clamps to one. Each primary color and
		// both extremes classify to their own entry; mid-gray falls just to
		// either side; yellow is equally far from white, red and green, and
		// the lowest of those wins. The write to the unmapped index must not
		// disturb any entry.
		write_reg(REG_TILE_WIDTH, 24'hFFFF80);
		write_reg(REG_TILE_HEIGHT, 24'h000001);
		write_reg(REG_PALETTE_0 + 3'd0, 24'h000000);
		write_reg(REG_PALETTE_0 + 3'd1, 24'hFFFFFF);
		write_reg(REG_PALETTE_0 + 3'd2, 24'hFF0000);
		write_reg(REG_PALETTE_0 + 3'd3, 24'h00FF00);
		write_reg(REG_PALETTE_0 + 3'd4, 24'h0000FF);
		write_reg(REG_UNMAPPED, 24'h123456);
		cfg_valid <= 1'b0;
		queue_pixel(8'h00, 8'h00, 8'h00);
		queue_pixel(8'hFF, 8'hFF, 8'hFF);
		queue_pixel(8'hFF, 8'h00, 8'h00);
		queue_pixel(8'h00, 8'hFF, 8'h00);
		queue_pixel(8'h00, 8'h00, 8'hFF);
		queue_pixel(8'h80, 8'h80, 8'h80);
		queue_pixel(8'h7F, 8'h7F, 8'h7F);
		queue_pixel(8'hFF, 8'hFF, 8'h00);
		wait_for_drain();

		// A zero height clamps to one as well. Entries 0 and 1 are equally far
		// from the first pixel; entries 3 and 4 are identical and the second
		// pixel sits on them.
		write_reg(REG_TILE_WIDTH, 24'h000001);
		write_reg(REG_TILE_HEIGHT, 24'h7FFF00);
		write_reg(REG_PALETTE_0 + 3'd1, 24'h020000);
		write_reg(REG_PALETTE_0 + 3'd3, 24'h406080);
		write_reg(REG_PALETTE_0 + 3'd4, 24'h406080);
		cfg_valid <= 1'b0;
		queue_pixel(8'h01, 8'h00, 8'h00);
		queue_pixel(8'h40, 8'h60, 8'h80);
		wait_for_drain();

		// Shrinking mid-tile: six pixels into a 4 by 4 tile, then the area
		// drops to one. The next pixel ends the tile with sums of seven pixels
		// divided by one, so two of the means saturate.
		write_reg(REG_TILE_WIDTH, 24'h800004);
		write_reg(REG_TILE_HEIGHT, 24'h000004);
		cfg_valid <= 1'b0;
		queue_tile(6, FILL_NEAR, 24'hFF1040);
		wait_for_drain();
		write_reg(REG_TILE_WIDTH, 24'h000001);
		write_reg(REG_TILE_HEIGHT, 24'h000001);
		cfg_valid <= 1'b0;
		queue_pixel(8'hFF, 8'h10, 8'h40);
		wait_for_drain();

		// Growing mid-tile: one pixel into a two-pixel tile, then the area
		// becomes four and the tile ends three pixels later.
		write_reg(REG_TILE_WIDTH, 24'h000002);
		cfg_valid <= 1'b0;
		queue_pixel(8'hA5, 8'h5A, 8'hC3);
		wait_for_drain();
		write_reg(REG_TILE_HEIGHT, 24'h000002);
		cfg_valid <= 1'b0;
		queue_tile(3, FILL_RANDOM, '0);
		wait_for_drain();

		// Random phases until the pixel budget is spent.
		random_target = pixels_queued + RANDOM_PIXELS;
		while (pixels_queued < random_target)
			random_phase();

		// One wide tile: an oversized width clamps to the maximum side, and
		// the first channel is all ones across the whole tile.
		write_reg(REG_TILE_WIDTH, 24'hFFFFFF);
		write_reg(REG_TILE_HEIGHT, 24'h000008);
		cfg_valid <= 1'b0;
		queue_tile(tile_area(), FILL_BRIGHT, '0);
		wait_for_drain();

		if (failures == 0) begin
			$display("** tile_mean_color_classifier: PASSED **");
		end else begin
			$display("** tile_mean_color_classifier: FAILED **");
		end
		$finish;
	end

endmodule
